// ===== sv/epr_pkg.sv =====
// Shared types and constants for the echo pulse ranging core.
package epr_pkg;

	localparam int TIME_W = 32;
	localparam int DIST_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W = TIME_W + CFG_DATA_W;

	localparam logic [CFG_IDX_W-1:0] CFG_MEDIAN_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

	localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 16'd5000;
	localparam logic [CFG_DATA_W-1:0] SCALE_RST = 16'd11141;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = 2;

	typedef struct packed {
		logic median_enable;
		logic [DIST_W-1:0] max_distance_mm;
		logic [CFG_DATA_W-1:0] scale_q16;
	} cfg_t;

endpackage

// ===== sv/echo_pulse_range_median_core.sv =====
// Echo pulse ranging core: rising-edge transfers store a timestamp, and each
// falling-edge transfer yields one result with the echo width (mod 2^32), the
// distance (width * scale_q16 >> 16, saturated to 65535) and, in median mode,
// the median of the last WINDOW_DEPTH distances clamped to max_distance_mm.
// One edge is accepted per cycle unless the queue is full. A falling edge's
// width passes the queue, then the multiplier stage, then median and result
// register; a four-entry queue lets input keep flowing while the output stalls.
// Configuration is to be written only while the core is idle (not enforced).
module echo_pulse_range_median_core #(
	parameter int WINDOW_DEPTH = 3
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [epr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [epr_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [epr_pkg::TIME_W-1:0] edge_time_us,
	input logic edge_level,
	output logic out_valid,
	input logic out_stall,
	output logic [epr_pkg::DIST_W-1:0] distance_mm,
	output logic [epr_pkg::TIME_W-1:0] echo_width_us,
	output logic clamped
);
	import epr_pkg::*;

	cfg_t cfg_q;
	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	logic [TIME_W-1:0] q_wdata;
	logic [TIME_W-1:0] q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.median_enable <= 1'b0;
			cfg_q.max_distance_mm <= MAX_DISTANCE_RST;
			cfg_q.scale_q16 <= SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MEDIAN_ENABLE: cfg_q.median_enable <= cfg_data[0];
				CFG_MAX_DISTANCE: cfg_q.max_distance_mm <= cfg_data;
				CFG_SCALE: cfg_q.scale_q16 <= cfg_data;
				default: ;
			endcase
		end
	end

	epr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.edge_time_us(edge_time_us),
		.edge_level(edge_level),
		.q_full(q_full),
		.q_push(q_push),
		.q_wdata(q_wdata)
	);

	epr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.rdata(q_rdata),
		.empty(q_empty)
	);

	epr_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_empty(q_empty),
		.q_rdata(q_rdata),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.distance_mm(distance_mm),
		.echo_width_us(echo_width_us),
		.clamped(clamped)
	);

endmodule

// ===== sv/epr_front.sv =====
// Front end: takes edge transfers, keeps the rise stamp, queues echo widths.
module epr_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [epr_pkg::TIME_W-1:0] edge_time_us,
	input logic edge_level,
	input logic q_full,
	output logic q_push,
	output logic [epr_pkg::TIME_W-1:0] q_wdata
);
	import epr_pkg::*;

	logic [TIME_W-1:0] rise_stamp_q;
	logic accept;

	assign in_stall = q_full;
	assign accept = in_valid && !q_full;
	assign q_push = accept && !edge_level;
	// width modulo 2^32
	assign q_wdata = edge_time_us - rise_stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_stamp_q <= '0;
		end else if (accept && edge_level) begin
			rise_stamp_q <= edge_time_us;
		end
	end

endmodule

// ===== sv/epr_queue.sv =====
// Small FIFO of echo widths between front and back end.
module epr_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [epr_pkg::TIME_W-1:0] wdata,
	output logic full,
	input logic pop,
	output logic [epr_pkg::TIME_W-1:0] rdata,
	output logic empty
);
	import epr_pkg::*;

	logic [TIME_W-1:0] entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0] count_q;

	assign full = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign rdata = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

endmodule

// ===== sv/epr_back.sv =====
// Back end: scales widths to distance, runs the median ring, holds the result register.
module epr_back #(
	parameter int WINDOW_DEPTH = 3
) (
	input logic clk,
	input logic arst_n,
	input epr_pkg::cfg_t cfg,
	input logic q_empty,
	input logic [epr_pkg::TIME_W-1:0] q_rdata,
	output logic q_pop,
	output logic out_valid,
	input logic out_stall,
	output logic [epr_pkg::DIST_W-1:0] distance_mm,
	output logic [epr_pkg::TIME_W-1:0] echo_width_us,
	output logic clamped
);
	import epr_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int MID = WINDOW_DEPTH / 2;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

	logic v_s1;
	logic [TIME_W-1:0] width_s1;
	logic [PROD_W-1:0] prod_s1;

	logic out_valid_q;
	logic [DIST_W-1:0] distance_q;
	logic [TIME_W-1:0] width_q;
	logic clamped_q;

	logic [DIST_W-1:0] ring_q [WINDOW_DEPTH];
	logic [PTR_W-1:0] ptr_q;
	logic [PTR_W-1:0] ptr_eff;

	logic adv;
	logic xfer;
	logic [DIST_W-1:0] dist_raw;
	logic [DIST_W-1:0] win [WINDOW_DEPTH];
	logic [PTR_W-1:0] rank [WINDOW_DEPTH];
	logic [DIST_W-1:0] med;
	logic [DIST_W-1:0] dist_next;
	logic clamped_next;

	assign adv = !out_valid_q || !out_stall;
	assign q_pop = !q_empty && (!v_s1 || adv);
	assign xfer = v_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || adv) begin
			v_s1 <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			width_s1 <= q_rdata;
			prod_s1 <= {{CFG_DATA_W{1'b0}}, q_rdata} * {{TIME_W{1'b0}}, cfg.scale_q16};
		end
	end

	// Q16 product back to mm, saturating
	assign dist_raw = (|prod_s1[PROD_W-1:TIME_W]) ? {DIST_W{1'b1}} : prod_s1[TIME_W-1:DIST_W];
	assign ptr_eff = (ptr_q > PTR_LAST) ? '0 : ptr_q;

	always_comb begin
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			win[i] = (ptr_eff == PTR_W'(i)) ? dist_raw : ring_q[i];
		end
	end

	// stable rank of each entry; the entry of middle rank is the median
	always_comb begin
		med = '0;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			rank[i] = '0;
			for (int j = 0; j < WINDOW_DEPTH; j++) begin
				if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
					rank[i] = rank[i] + PTR_W'(1);
				end
			end
		end
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			if (rank[i] == PTR_W'(MID)) begin
				med = win[i];
			end
		end
	end

	always_comb begin
		dist_next = dist_raw;
		clamped_next = 1'b0;
		if (cfg.median_enable) begin
			if (med < cfg.max_distance_mm) begin
				dist_next = med;
			end else begin
				dist_next = cfg.max_distance_mm;
				clamped_next = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			ptr_q <= PTR_W'(1);
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			if (adv) begin
				out_valid_q <= v_s1;
			end
			if (xfer && cfg.median_enable) begin
				ring_q[ptr_eff] <= dist_raw;
				ptr_q <= (ptr_eff == PTR_LAST) ? '0 : ptr_eff + PTR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			distance_q <= dist_next;
			width_q <= width_s1;
			clamped_q <= clamped_next;
		end
	end

	assign out_valid = out_valid_q;
	assign distance_mm = distance_q;
	assign echo_width_us = width_q;
	assign clamped = clamped_q;

endmodule

// ===== dv/echo_pulse_range_median_core_test.sv =====
// Self-checking testbench for echo_pulse_range_median_core: directed and random edge transfers.
module echo_pulse_range_median_core_test;
	import epr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int WINDOW = 3;
	localparam int Q_FRAC = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 12;
	localparam int ITEMS_PER_PHASE = 88;
	localparam int RANDOM_PHASES = 8;

	typedef struct packed {
		logic [TIME_W-1:0] stamp;
		logic rising;
	} edge_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] dist_mm;
		logic [TIME_W-1:0] width;
		logic clamped;
	} range_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic [TIME_W-1:0] edge_time_us = '0;
	logic edge_level = 1'b0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic [DIST_W-1:0] distance_mm;
	logic [TIME_W-1:0] echo_width_us;
	logic clamped;

	edge_item_t edge_queue[$];
	range_result_t expected_ranges[$];
	edge_item_t next_edge;
	bit edge_taken = 1'b0;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;

	cfg_t model_cfg = '{1'b0, MAX_DISTANCE_RST, SCALE_RST};
	logic [TIME_W-1:0] rise_stamp_q = '0;
	logic [DIST_W-1:0] ring[WINDOW] = '{default: '0};
	int ring_ptr = 1;

	int cycles = 0;
	int mismatches = 0;
	int edges_accepted = 0;
	int results_checked = 0;
	int median_results = 0;
	int clamped_results = 0;
	int settings_used = 0;

	echo_pulse_range_median_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.edge_time_us(edge_time_us),
		.edge_level(edge_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.distance_mm(distance_mm),
		.echo_width_us(echo_width_us),
		.clamped(clamped)
	);

	always #6 clk = ~clk;

	task automatic predict_edge(input edge_item_t it);
		range_result_t r;
		logic [PROD_W-1:0] prod;
		logic [DIST_W-1:0] lo, hi, med;
		if (it.rising) begin
			rise_stamp_q = it.stamp;
		end else begin
			r.width = it.stamp - rise_stamp_q;
			r.clamped = 1'b0;
			prod = PROD_W'(r.width) * PROD_W'(model_cfg.scale_q16);
			if (prod[PROD_W-1:Q_FRAC+DIST_W] != 0)
				r.dist_mm = '1;
			else
				r.dist_mm = prod[Q_FRAC+DIST_W-1:Q_FRAC];
			if (model_cfg.median_enable) begin
				if (ring_ptr >= WINDOW)
					ring_ptr = 0;
				ring[ring_ptr] = r.dist_mm;
				ring_ptr = (ring_ptr + 1 >= WINDOW) ? 0 : ring_ptr + 1;
				lo = (ring[0] < ring[1]) ? ring[0] : ring[1];
				hi = (ring[0] < ring[1]) ? ring[1] : ring[0];
				med = (ring[2] <= lo) ? lo : (ring[2] >= hi) ? hi : ring[2];
				if (med < model_cfg.max_distance_mm) begin
					r.dist_mm = med;
				end else begin
					r.dist_mm = model_cfg.max_distance_mm;
					r.clamped = 1'b1;
				end
			end
			expected_ranges.push_back(r);
		end
	endtask

	// input side: feed the next edge once the current one is transferred
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || edge_taken) begin
				if (edge_queue.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
					next_edge = edge_queue.pop_front();
					in_valid <= 1'b1;
					edge_time_us <= next_edge.stamp;
					edge_level <= next_edge.rising;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

	// monitor: check results first, then predict from the accepted edge
	always @(posedge clk) begin
		range_result_t exp_r;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("echo_pulse_range_median_core test failed");
			$finish;
		end
		edge_taken = arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ranges.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: dist %0d width %h clamped %0d",
						distance_mm, echo_width_us, clamped);
			end else begin
				exp_r = expected_ranges.pop_front();
				results_checked++;
				if (model_cfg.median_enable)
					median_results++;
				if (exp_r.clamped)
					clamped_results++;
				if (distance_mm !== exp_r.dist_mm || echo_width_us !== exp_r.width ||
						clamped !== exp_r.clamped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch (exp/act): dist %0d/%0d width %h/%h clamped %0d/%0d",
							exp_r.dist_mm, distance_mm, exp_r.width, echo_width_us,
							exp_r.clamped, clamped);
				end
			end
		end
		if (edge_taken) begin
			edges_accepted++;
			predict_edge('{edge_time_us, edge_level});
		end
	end

	task automatic add_edge(input logic [TIME_W-1:0] stamp, input logic rising);
		edge_queue.push_back('{stamp, rising});
	endtask

	task automatic add_echo(input logic [TIME_W-1:0] start, input logic [TIME_W-1:0] width);
		add_edge(start, 1'b1);
		add_edge(start + width, 1'b0);
	endtask

	function automatic logic [TIME_W-1:0] rand_width();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return $urandom_range(50);
		if (pick < 70)
			return $urandom_range(40000);
		if (pick < 90)
			return $urandom_range(1000000);
		return $urandom;
	endfunction

	task automatic add_random_edges(input int count);
		int added;
		int pick;
		logic [TIME_W-1:0] start;
		added = 0;
		while (added < count) begin
			pick = $urandom_range(99);
			start = $urandom;
			if (pick < 75) begin
				add_echo(start, rand_width());
				added += 2;
			end else if (pick < 85) begin
				add_edge($urandom, 1'b1);
				add_echo(start, rand_width());
				added += 3;
			end else if (pick < 93) begin
				add_edge(start, 1'b0);
				added++;
			end else begin
				add_edge(start, 1'b1);
				added++;
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (edge_queue.size() != 0 || in_valid || expected_ranges.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		case (idx)
			CFG_MEDIAN_ENABLE: model_cfg.median_enable = val[0];
			CFG_MAX_DISTANCE: model_cfg.max_distance_mm = val;
			CFG_SCALE: model_cfg.scale_q16 = val;
			default: ;
		endcase
	endtask

	// called only from a negedge with the core idle
	task automatic apply_settings(input logic en, input logic [DIST_W-1:0] max_d,
			input logic [CFG_DATA_W-1:0] scale);
		write_reg(CFG_MEDIAN_ENABLE, {15'($urandom), en});
		write_reg(CFG_MAX_DISTANCE, max_d);
		write_reg(CFG_UNUSED, 16'($urandom));
		write_reg(CFG_SCALE, scale);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic en_set[RANDOM_PHASES];
		logic [DIST_W-1:0] max_set[RANDOM_PHASES];
		logic [CFG_DATA_W-1:0] scale_set[RANDOM_PHASES];
		en_set = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
		max_set = '{16'd5000, 16'd5000, 16'hFFFF, 16'hFFFF, 16'd0, 16'($urandom),
			16'($urandom), 16'd1500};
		scale_set = '{SCALE_RST, SCALE_RST, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF,
			16'($urandom), 16'd1};

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: falls with no rise, repeated rises and falls, wrap, saturation
		settings_used = 1;
		add_edge(32'd1000, 1'b0);
		add_edge(32'd0, 1'b0);
		add_edge(32'd5000, 1'b1);
		add_edge(32'd7000, 1'b1);
		add_edge(32'd7100, 1'b0);
		add_edge(32'd9000, 1'b0);
		add_echo(32'hFFFF_FF00, 32'h200);
		add_echo(32'd0, 32'hFFFF_FFFF);
		wait_idle();

		// median over a ring still holding reset zeros
		apply_settings(1'b1, 16'hFFFF, 16'hFFFF);
		@(posedge clk);
		add_echo(32'd100, 32'd10);
		add_echo($urandom, 32'd20);
		wait_idle();

		// median below the clamp, then equal to it
		apply_settings(1'b1, 16'd3000, SCALE_RST);
		snd_idle_pct = 30;
		rcv_stall_pct = 30;
		@(posedge clk);
		repeat (3) add_echo($urandom, 32'd17648);
		repeat (2) add_echo($urandom, 32'd100);
		wait_idle();

		apply_settings(1'b1, 16'd0, 16'd0);
		@(posedge clk);
		add_echo($urandom, 32'hFFFF_FFFF);
		wait_idle();

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			apply_settings(en_set[k], max_set[k], scale_set[k]);
			snd_idle_pct = (k % 4 == 1) ? 55 : (k % 4 == 3) ? 30 : 0;
			rcv_stall_pct = (k % 4 == 2) ? 55 : (k % 4 == 3) ? 30 : 0;
			@(posedge clk);
			add_random_edges(ITEMS_PER_PHASE);
			wait_idle();
		end

		$display("covered %0d edge transfers, %0d results checked (%0d median, %0d clamped)",
			edges_accepted, results_checked, median_results, clamped_results);
		$display("across %0d register settings and four idle/stall mixes, %0d mismatches",
			settings_used, mismatches);
		if (mismatches == 0 && expected_ranges.size() == 0)
			$display("echo_pulse_range_median_core test passed");
		else
			$display("echo_pulse_range_median_core test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/epr_pkg.sv
sv/epr_front.sv
sv/epr_queue.sv
sv/epr_back.sv
sv/echo_pulse_range_median_core.sv
dv/echo_pulse_range_median_core_test.sv
